// ===== rtl/core/door_motor_supervisor_top_assert.svh =====
// Assertion macros for the door motor supervisor checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DOOR_MOTOR_SUPERVISOR_TOP_ASSERT_SVH
`define DOOR_MOTOR_SUPERVISOR_TOP_ASSERT_SVH

// Checked outside reset.
`define DMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define DMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/core/dms_pkg.sv =====
// Door motor supervisor package: constants, codes and types.
// No dependencies; imported by door_motor_supervisor_top.
package dms_pkg;

    localparam int AVG_DEPTH      = 10;
    localparam int ADC_FULL_SCALE = 1024;
    localparam int ADC_SHIFT      = $clog2(ADC_FULL_SCALE);
    localparam int IDX_W          = $clog2(AVG_DEPTH);
    localparam int AVG_SHIFT      = 19;
    localparam int AVG_RECIP      = (2 ** AVG_SHIFT + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int MA_PER_A       = 1000;

    localparam int ADC_W   = 10;
    localparam int MV_W    = 13;
    localparam int MA_W    = 16;
    localparam int AVG_W   = 13;
    localparam int QUO_W   = 23;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_OPEN  = 2'd1,
        KIND_CLOSE = 2'd2
    } kind_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_ADC_ZERO  = 3'd0,
        CFG_VREF      = 3'd1,
        CFG_SENS      = 3'd2,
        CFG_LIMIT     = 3'd3,
        CFG_PERIOD    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_MV,
        ST_DIV_LD,
        ST_DIV,
        ST_STORE,
        ST_MUL_AVG,
        ST_AVG_LD,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic up;
        logic down;
        logic dwatch;
        logic awatch;
        logic cwatch;
        logic paused;
        logic open;
        logic closed;
        logic oc;
    } ctrl_t;

    // lowest bit last: relay_up lands in bit 0
    typedef struct packed {
        logic [AVG_W-1:0] average_ma;
        logic             obstacle_pause;
        logic             overcurrent_stop;
        logic             door_closed;
        logic             door_open;
        logic             relay_down;
        logic             relay_up;
    } result_t;

    function automatic ctrl_t halt_all(ctrl_t c);
        ctrl_t r;
        r        = c;
        r.up     = 1'b0;
        r.down   = 1'b0;
        r.dwatch = 1'b0;
        r.awatch = 1'b0;
        r.cwatch = 1'b0;
        r.paused = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/door_motor_supervisor_top.sv =====
// Door motor supervisor: command/tick stream in, relay and status stream out.
// Depends on dms_pkg.
//
// Usage:
//   s_ channel: one beat per command or tick; s_tuser carries the kind
//   (tick, open, close). m_ channel: one result beat per input beat, the
//   relay drives and flags after that item plus the ring average in mA.
//   cfg_*: register writes; write them only while the block is idle.
// Processing:
//   A beat that stores no current sample passes EVAL and APPLY; its result
//   is registered and drives m_tvalid. A tick that stores a sample runs
//   EVAL, MUL_MV, DIV_LD, DIV, STORE, MUL_AVG, AVG_LD and APPLY: one shared
//   16x16 multiplier is used three times (ADC to mV, mV to mA scaling,
//   ring average by reciprocal) and the mA conversion runs a restoring
//   divider, one quotient bit per cycle.
//   One item is in work at a time; s_tready is high only while idle, and a
//   new beat can be taken while the previous result still waits.
// Reset (aresetn low, synchronous): defaults, relays off, flags, ring and sum cleared.
// Stall: if m_tready is low a finished result holds in the output
//   register; the next item waits in its last step until that beat leaves.
module door_motor_supervisor_top
    import dms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [CFG_D_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] arm_current, [1] arm_limits, [2] limit_high, [3] limit_low,
    // [4] beam_clear, [14:5] adc_sample, [46:15] now_ms, [47] zero
    input  logic [47:0]          s_tdata,
    // [1:0] kind
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] relay_up, [1] relay_down, [2] door_open, [3] door_closed,
    // [4] overcurrent_stop, [5] obstacle_pause, [18:6] average_ma, [23:19] zero
    output logic [23:0]          m_tdata
);

    logic [ADC_W-1:0]  adc_zero_reg;
    logic [12:0]       vref_reg;
    logic [9:0]        sens_reg;
    logic [15:0]       limit_reg;
    logic [15:0]       period_reg;

    state_t            state_reg, state_next;
    ctrl_t             ctrl_reg, ctrl_next;
    logic [MA_W-1:0]   ring_reg [AVG_DEPTH];
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       last_reg, last_next;
    logic [MA_W-1:0]   sum_reg, sum_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic              m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [1:0]        kind_reg;
    logic [47:0]       in_reg;
    logic [31:0]       prod_reg;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [9:0]        rem_reg, rem_next;
    result_t           result_reg;

    logic              in_chk_cur, in_chk_sen, in_lim_hi, in_lim_lo, in_beam;
    logic [ADC_W-1:0]  in_adc;
    logic [31:0]       in_now;
    logic [ADC_W-1:0]  delta;
    logic [31:0]       elapsed;
    logic [15:0]       mul_a, mul_b;
    logic [31:0]       mul_p;
    logic [10:0]       rem_sh;
    logic              div_ge;
    logic [MA_W-1:0]   ma_val;
    logic [IDX_W-1:0]  wr_idx;
    logic              ring_wr;
    logic              res_load;
    logic              s_acc;
    ctrl_t             applied;

    assign in_chk_cur = in_reg[0];
    assign in_chk_sen = in_reg[1];
    assign in_lim_hi  = in_reg[2];
    assign in_lim_lo  = in_reg[3];
    assign in_beam    = in_reg[4];
    assign in_adc     = in_reg[14:5];
    assign in_now     = in_reg[46:15];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, result_reg};

    assign delta   = (in_adc < adc_zero_reg) ? (adc_zero_reg - in_adc) : (in_adc - adc_zero_reg);
    assign elapsed = in_now - last_reg;
    assign mul_p   = mul_a * mul_b;

    // restoring divider step
    assign rem_sh = {rem_reg, quo_reg[QUO_W-1]};
    assign div_ge = (rem_sh >= {1'b0, sens_reg});
    assign ma_val = ((sens_reg == '0) || (|quo_reg[QUO_W-1:MA_W])) ? {MA_W{1'b1}}
                                                                  : quo_reg[MA_W-1:0];
    assign wr_idx = (idx_reg >= IDX_W'(AVG_DEPTH)) ? '0 : idx_reg;

    always_comb begin
        ctrl_t c;
        c = ctrl_reg;
        case (kind_t'(kind_reg))
            KIND_TICK: begin
                if (c.cwatch && ({3'b0, avg_reg} > limit_reg)) begin
                    c    = halt_all(c);
                    c.oc = 1'b1;
                end
                if (c.dwatch) begin
                    if (in_lim_lo) begin
                        c        = halt_all(c);
                        c.closed = 1'b1;
                    end else if (!in_beam && !c.paused) begin
                        c.up     = 1'b0;
                        c.down   = 1'b0;
                        c.paused = 1'b1;
                    end else if (in_beam && c.paused) begin
                        c.up     = 1'b0;
                        c.down   = 1'b1;
                        c.paused = 1'b0;
                    end
                end
                if (c.awatch && in_lim_hi) begin
                    c      = halt_all(c);
                    c.open = 1'b1;
                end
            end
            KIND_OPEN: begin
                c.open   = 1'b0;
                c.closed = 1'b0;
                c.dwatch = 1'b0;
                c.paused = 1'b0;
                c.cwatch = in_chk_cur;
                if (in_chk_sen) begin
                    c.awatch = 1'b1;
                end
                if (!in_lim_hi) begin
                    c.up   = 1'b1;
                    c.down = 1'b0;
                end
            end
            KIND_CLOSE: begin
                c.open   = 1'b0;
                c.closed = 1'b0;
                c.awatch = 1'b0;
                c.cwatch = in_chk_cur;
                if (in_chk_sen) begin
                    c.dwatch = 1'b1;
                end
                if (!in_lim_lo && in_beam) begin
                    c.up   = 1'b0;
                    c.down = 1'b1;
                end
            end
            default: begin
            end
        endcase
        applied = c;
    end

    always_comb begin
        state_next = state_reg;
        ctrl_next  = ctrl_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        sum_next   = sum_reg;
        avg_next   = avg_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        mul_a      = '0;
        mul_b      = '0;
        ring_wr    = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                mul_a = {{(16-ADC_W){1'b0}}, delta};
                mul_b = {3'b0, vref_reg};
                if ((kind_t'(kind_reg) == KIND_TICK) && ctrl_reg.cwatch &&
                    (elapsed > {16'b0, period_reg})) begin
                    state_next = ST_MUL_MV;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_MUL_MV: begin
                mul_a      = {3'b0, prod_reg[ADC_SHIFT +: MV_W]};
                mul_b      = 16'(MA_PER_A);
                state_next = ST_DIV_LD;
            end
            ST_DIV_LD: begin
                quo_next   = prod_reg[QUO_W-1:0];
                rem_next   = '0;
                cnt_next   = CNT_W'(QUO_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = div_ge ? 10'(rem_sh - {1'b0, sens_reg}) : rem_sh[9:0];
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                ring_wr    = 1'b1;
                sum_next   = sum_reg - ring_reg[wr_idx] + ma_val;
                idx_next   = (wr_idx == IDX_W'(AVG_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
                last_next  = in_now;
                state_next = ST_MUL_AVG;
            end
            ST_MUL_AVG: begin
                mul_a      = sum_reg;
                mul_b      = 16'(AVG_RECIP);
                state_next = ST_AVG_LD;
            end
            ST_AVG_LD: begin
                avg_next   = prod_reg[AVG_SHIFT +: AVG_W];
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (!m_valid_reg || m_tready) begin
                    ctrl_next  = applied;
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_zero_reg <= 10'd512;
            vref_reg     <= 13'd5000;
            sens_reg     <= 10'd185;
            limit_reg    <= 16'd1000;
            period_reg   <= 16'd100;
            state_reg    <= ST_IDLE;
            ctrl_reg     <= '0;
            for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            idx_reg      <= '0;
            last_reg     <= '0;
            sum_reg      <= '0;
            avg_reg      <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_ADC_ZERO: adc_zero_reg <= cfg_wdata[ADC_W-1:0];
                    CFG_VREF:     vref_reg     <= cfg_wdata[12:0];
                    CFG_SENS:     sens_reg     <= cfg_wdata[9:0];
                    CFG_LIMIT:    limit_reg    <= cfg_wdata;
                    CFG_PERIOD:   period_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            state_reg   <= state_next;
            ctrl_reg    <= ctrl_next;
            if (ring_wr) begin
                ring_reg[wr_idx] <= ma_val;
            end
            idx_reg     <= idx_next;
            last_reg    <= last_next;
            sum_reg     <= sum_next;
            avg_reg     <= avg_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_reg   <= s_tdata;
            kind_reg <= s_tuser;
        end
        prod_reg <= mul_p;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        if (res_load) begin
            result_reg.relay_up         <= applied.up;
            result_reg.relay_down       <= applied.down;
            result_reg.door_open        <= applied.open;
            result_reg.door_closed      <= applied.closed;
            result_reg.overcurrent_stop <= applied.oc;
            result_reg.obstacle_pause   <= applied.paused;
            result_reg.average_ma       <= avg_reg;
        end
    end

endmodule

// ===== rtl/core/dms_checker.sv =====
// Port-level checker for door_motor_supervisor_top, bound to the top level.
// Depends on door_motor_supervisor_top_assert.svh.
`include "door_motor_supervisor_top_assert.svh"

module dms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `DMS_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "beat accepted while busy")
    `DMS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result beat changed")
    `DMS_ASSERT(a_relay_excl, aclk, aresetn, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "both relays driven")
    `DMS_ASSERT(a_avg_range, aclk, aresetn, m_tvalid |-> (m_tdata[18:6] <= 13'd6553), "average out of range")
    `DMS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind door_motor_supervisor_top dms_checker u_dms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// Self-checking testbench for door_motor_supervisor_top: commands and ticks go in
// as stream beats, each status beat is checked against an in-bench door model.
// Depends on dms_pkg and door_motor_supervisor_top.
`timescale 1ns / 100ps

module tb
    import dms_pkg::*;
();

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int HOLD_LEN = 600;
    localparam int SETTLE = 40;

    typedef struct {
        logic [1:0]  kind;
        logic        chk_cur;
        logic        chk_sen;
        logic        lim_hi;
        logic        lim_lo;
        logic        beam;
        logic [9:0]  adc;
        logic [31:0] now;
    } door_item_t;

    class door_result_board;
        logic [9:0]  zero_ref;
        logic [12:0] vref;
        logic [9:0]  sens;
        logic [15:0] limit;
        logic [15:0] period;
        logic        up, down, dwatch, awatch, cwatch, paused, opened, closed, oc;
        logic [15:0] ring [AVG_DEPTH];
        int          ring_pos;
        logic [31:0] last_t;
        result_t     pending_status [$];
        int          errors;

        function new();
            zero_ref = 10'd512;
            vref     = 13'd5000;
            sens     = 10'd185;
            limit    = 16'd1000;
            period   = 16'd100;
            {up, down, dwatch, awatch, cwatch, paused, opened, closed, oc} = '0;
            foreach (ring[k]) ring[k] = '0;
            ring_pos = 0;
            last_t   = '0;
            errors   = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_ADC_ZERO: zero_ref = v[9:0];
                CFG_VREF:     vref = v[12:0];
                CFG_SENS:     sens = v[9:0];
                CFG_LIMIT:    limit = v;
                CFG_PERIOD:   period = v;
                default: ;
            endcase
        endfunction

        function void stop_motor();
            {up, down, dwatch, awatch, cwatch, paused} = '0;
        endfunction

        function logic [15:0] adc_to_ma(logic [9:0] adc);
            longint unsigned delta, mv, ma;
            delta = (adc < zero_ref) ? zero_ref - adc : adc - zero_ref;
            mv = (delta * vref) / ADC_FULL_SCALE;
            if (sens == 0)
                return 16'hFFFF;
            ma = (mv * 1000) / sens;
            if (ma > 64'hFFFF)
                ma = 64'hFFFF;
            return ma[15:0];
        endfunction

        function logic [12:0] ring_mean_ma();
            logic [15:0] sum;
            sum = '0;
            foreach (ring[k]) sum += ring[k];
            return 13'(sum / AVG_DEPTH);
        endfunction

        function void take_item(door_item_t it);
            result_t     r;
            logic [31:0] elapsed;
            case (it.kind)
                KIND_TICK: begin
                    if (cwatch) begin
                        elapsed = it.now - last_t;
                        if (elapsed > {16'd0, period}) begin
                            if (ring_pos >= AVG_DEPTH)
                                ring_pos = 0;
                            ring[ring_pos] = adc_to_ma(it.adc);
                            last_t = it.now;
                            ring_pos++;
                            if (ring_pos >= AVG_DEPTH)
                                ring_pos = 0;
                        end
                        if (ring_mean_ma() > limit) begin
                            stop_motor();
                            oc = 1'b1;
                        end
                    end
                    if (dwatch) begin
                        if (it.lim_lo) begin
                            stop_motor();
                            closed = 1'b1;
                        end else if (!it.beam && !paused) begin
                            up = 1'b0;
                            down = 1'b0;
                            paused = 1'b1;
                        end else if (it.beam && paused) begin
                            up = 1'b0;
                            down = 1'b1;
                            paused = 1'b0;
                        end
                    end
                    if (awatch && it.lim_hi) begin
                        stop_motor();
                        opened = 1'b1;
                    end
                end
                KIND_OPEN: begin
                    opened = 1'b0;
                    closed = 1'b0;
                    dwatch = 1'b0;
                    paused = 1'b0;
                    cwatch = it.chk_cur;
                    if (it.chk_sen)
                        awatch = 1'b1;
                    if (!it.lim_hi) begin
                        up = 1'b1;
                        down = 1'b0;
                    end
                end
                KIND_CLOSE: begin
                    opened = 1'b0;
                    closed = 1'b0;
                    awatch = 1'b0;
                    cwatch = it.chk_cur;
                    if (it.chk_sen)
                        dwatch = 1'b1;
                    if (!it.lim_lo && it.beam) begin
                        up = 1'b0;
                        down = 1'b1;
                    end
                end
                default: ;
            endcase
            r.relay_up         = up;
            r.relay_down       = down;
            r.door_open        = opened;
            r.door_closed      = closed;
            r.overcurrent_stop = oc;
            r.obstacle_pause   = paused;
            r.average_ma       = ring_mean_ma();
            pending_status.push_back(r);
        endfunction

        function void field_check(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_status(logic [23:0] beat);
            result_t want;
            if (pending_status.size() == 0) begin
                errors++;
                $display("%0t: status beat expected none actual %h", $time, beat);
                return;
            end
            want = pending_status.pop_front();
            field_check("relay_up", want.relay_up, beat[0]);
            field_check("relay_down", want.relay_down, beat[1]);
            field_check("door_open", want.door_open, beat[2]);
            field_check("door_closed", want.door_closed, beat[3]);
            field_check("overcurrent_stop", want.overcurrent_stop, beat[4]);
            field_check("obstacle_pause", want.obstacle_pause, beat[5]);
            field_check("average_ma", want.average_ma, beat[18:6]);
            field_check("pad", 0, beat[23:19]);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0]   cfg_addr = '0;
    logic [CFG_D_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_req = 1'b0;
    logic [31:0] clock_ms = '0;

    door_result_board sb = new;

    door_motor_supervisor_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls, or one long hold-off when requested
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && held < HOLD_LEN) begin
                m_tready <= 1'b0;
                held++;
            end else begin
                if (!hold_req)
                    held = 0;
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_status(m_tdata);
    end

    function automatic door_item_t make_item(logic [1:0] kind, bit cc, bit cs, bit lh, bit ll,
                                             bit bc, logic [9:0] adc, logic [31:0] now);
        door_item_t it;
        it.kind    = kind;
        it.chk_cur = cc;
        it.chk_sen = cs;
        it.lim_hi  = lh;
        it.lim_lo  = ll;
        it.beam    = bc;
        it.adc     = adc;
        it.now     = now;
        return it;
    endfunction

    function automatic logic [9:0] pick_adc();
        int a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                a = int'(sb.zero_ref) + int'($urandom_range(0, 40)) - 20;
                if (a < 0) a = 0;
                if (a > 1023) a = 1023;
            end
            5, 6, 7: a = $urandom_range(0, 1023);
            8:       a = 0;
            default: a = 1023;
        endcase
        return a[9:0];
    endfunction

    function automatic logic [31:0] next_ms_step();
        logic [31:0] p;
        p = {16'd0, sb.period};
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, p);
            3:       return p;
            4, 5:    return p + 1;
            6, 7, 8: return p + 1 + $urandom_range(0, 200);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(door_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {1'b0, it.now, it.adc, it.beam, it.lim_lo, it.lim_hi,
                     it.chk_sen, it.chk_cur};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic load_regs(logic [15:0] z, logic [15:0] v, logic [15:0] s,
                             logic [15:0] l, logic [15:0] p);
        cfg_idx_t    regs [5] = '{CFG_ADC_ZERO, CFG_VREF, CFG_SENS, CFG_LIMIT, CFG_PERIOD};
        logic [15:0] vals [5];
        vals = '{z, v, s, l, p};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // mostly a command followed by a run of ticks, some stray beats
    task automatic run_traffic(int count);
        int          sent;
        int          ticks;
        logic [1:0]  dir;
        door_item_t  it;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) != 0) begin
                dir = $urandom_range(0, 1) ? KIND_OPEN : KIND_CLOSE;
                it = make_item(dir, $urandom_range(0, 6) != 0, $urandom_range(0, 6) != 0,
                               $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                               $urandom_range(0, 7) != 0, pick_adc(), $urandom());
                send_item(it);
                sent++;
                ticks = $urandom_range(3, 14);
                repeat (ticks) begin
                    clock_ms += next_ms_step();
                    it = make_item(KIND_TICK, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)),
                                   (dir == KIND_OPEN) ? $urandom_range(0, 11) == 0
                                                      : $urandom_range(0, 30) == 0,
                                   (dir == KIND_CLOSE) ? $urandom_range(0, 11) == 0
                                                       : $urandom_range(0, 30) == 0,
                                   $urandom_range(0, 5) != 0, pick_adc(), clock_ms);
                    send_item(it);
                    sent++;
                end
            end else begin
                clock_ms += next_ms_step();
                it = make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               10'($urandom_range(0, 1023)),
                               $urandom_range(0, 1) ? $urandom() : clock_ms);
                send_item(it);
                sent++;
            end
        end
    endtask

    task automatic run_phase(int tx, int rx, bit hold, logic [15:0] z, logic [15:0] v,
                             logic [15:0] s, logic [15:0] l, logic [15:0] p, int count);
        drain();
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        load_regs(z, v, s, l, p);
        hold_req = hold;
        run_traffic(count);
        hold_req = 1'b0;
    endtask

    initial begin
        int mode;
        int tx, rx;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values in force
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 10'd0, 32'd0));
        send_item(make_item(KIND_SPARE, 1, 1, 1, 1, 1, 10'd1023, 32'hFFFF_FFFF));
        send_item(make_item(KIND_OPEN, 0, 1, 0, 0, 1, 10'd0, 32'd0));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 1, 10'd0, 32'd10));
        send_item(make_item(KIND_TICK, 0, 0, 1, 0, 1, 10'd0, 32'd20));
        // open at the upper limit: drive stays as it was
        send_item(make_item(KIND_OPEN, 0, 1, 1, 0, 1, 10'd0, 32'd30));
        send_item(make_item(KIND_CLOSE, 0, 1, 0, 0, 1, 10'd0, 32'd40));
        // beam blocked, still blocked, clear again, blocked again
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 10'd0, 32'd50));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 10'd0, 32'd60));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 1, 10'd0, 32'd70));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 10'd0, 32'd80));
        // open while paused clears the pause
        send_item(make_item(KIND_OPEN, 0, 0, 0, 0, 1, 10'd0, 32'd90));
        send_item(make_item(KIND_CLOSE, 0, 1, 0, 0, 0, 10'd0, 32'd95));
        send_item(make_item(KIND_TICK, 0, 0, 0, 1, 1, 10'd0, 32'd96));
        send_item(make_item(KIND_CLOSE, 0, 1, 0, 1, 1, 10'd0, 32'd97));
        send_item(make_item(KIND_CLOSE, 1, 0, 0, 0, 1, 10'd0, 32'd98));
        // elapsed equal to the period does not sample
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 1, 10'd0, 32'd100));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 1, 10'd512, 32'd101));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 1, 10'd600, 32'hFFFF_FFF0));
        // time wraps past zero
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 1, 10'd0, 32'h0000_0050));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 1, 10'd0, 32'h0000_0055));
        send_item(make_item(KIND_OPEN, 1, 1, 0, 0, 1, 10'd0, 32'h0000_0060));
        send_item(make_item(KIND_TICK, 1, 1, 0, 0, 1, 10'd1023, 32'h0000_0200));
        clock_ms = 32'h0000_0200;

        run_phase(0, 0, 0, 16'd512, 16'd5000, 16'd185, 16'd65535, 16'd100, 150);
        run_phase(86, 0, 0, 16'd0, 16'd5000, 16'd1, 16'd0, 16'd0, 120);
        run_phase(0, 86, 0, 16'd1023, 16'd1, 16'd1000, 16'd65535, 16'd65535, 120);
        run_phase(23, 23, 0, 16'($urandom_range(0, 1023)), 16'($urandom_range(1, 5000)),
                  16'd0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 300)), 150);
        run_phase(0, 0, 1, 16'd512, 16'd5000, 16'd185, 16'd1000, 16'd100, 100);
        for (int n = 0; n < 3; n++) begin
            mode = $urandom_range(0, 3);
            case (mode)
                0:       begin tx = 0;  rx = 0;  end
                1:       begin tx = 86; rx = 0;  end
                2:       begin tx = 0;  rx = 86; end
                default: begin tx = 23; rx = 23; end
            endcase
            run_phase(tx, rx, 0, 16'($urandom_range(0, 1023)), 16'($urandom_range(1, 5000)),
                      16'($urandom_range(1, 1000)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 400)), 100);
        end
        drain();

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
